>>> src/ufr_pkg.sv
// Shared types and constants for the UART frame receiver.
// Used by every module of the block; depends on nothing.

package ufr_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int COUNT_MAX    = 511;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam logic [7:0] END_BYTE   = 8'hEF;

	typedef enum logic [1:0] {
		CLS_DATA,
		CLS_HEADER,
		CLS_END
	} byte_class_t;

	// One classified byte as it travels from the front to the back.
	typedef struct packed {
		byte_class_t cls;
		logic [7:0]  rx_byte;
		logic [7:0]  slot;
		logic [7:0]  next_slot;
	} item_t;

	// Occupancy flags of the queue between front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> src/ufr_if.sv
// Channel interfaces of the UART frame receiver: received bytes in, results out.
// Depends on nothing.

interface ufr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] write_index;
	logic       frame_ok;
	logic       frame_bad;
	logic [7:0] frame_start;
	logic [8:0] frame_length;

	modport source (output valid, output write_index, output frame_ok, output frame_bad,
		output frame_start, output frame_length, input ready);
	modport sink (input valid, input write_index, input frame_ok, input frame_bad,
		input frame_start, input frame_length, output ready);
endinterface

>>> src/uart_frame_receiver.sv
// A taken byte is queued, then moved into the back part's output register once
// it is free. Throughput: one byte per cycle while results are taken; that
// output register is the only stage that holds a result, and a two-entry queue
// separates it from the front.
// Reset (asynchronous, active low) clears the write pointer, previous byte,
// sum, length, start index, frame flags and empties the queue.

module uart_frame_receiver #(
	parameter int BUFFER_DEPTH = ufr_pkg::BUFFER_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ufr_in_if.sink    rx,
	ufr_out_if.source result
);

	logic                   push_valid;
	logic                   push_ready;
	ufr_pkg::item_t         push_item;
	logic                   pop_valid;
	logic                   pop_ready;
	ufr_pkg::item_t         pop_item;
	ufr_pkg::queue_status_t status;

	ufr_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	ufr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.status    (status)
	);

	ufr_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.status   (status),
		.result   (result)
	);

endmodule

>>> src/ufr_front.sv
// Front part: takes received bytes, assigns ring slots and classifies header,
// end and data bytes. Depends on ufr_pkg and ufr_in_if.

module ufr_front #(
	parameter int BUFFER_DEPTH = ufr_pkg::BUFFER_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	ufr_in_if.sink         rx,
	output logic           push_valid,
	input  logic           push_ready,
	output ufr_pkg::item_t push_item
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_next;
	logic [7:0]       prev_q;
	logic [PTR_W+7:0] slot_ext;
	logic [PTR_W+7:0] next_ext;
	logic             accept;

	assign accept   = rx.valid && push_ready;
	assign rx.ready = push_ready;
	assign ptr_next = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
	assign slot_ext = {8'd0, ptr_q};
	assign next_ext = {8'd0, ptr_next};

	always_comb begin
		push_valid          = rx.valid;
		push_item.rx_byte   = rx.rx_byte;
		push_item.slot      = slot_ext[7:0];
		push_item.next_slot = next_ext[7:0];
		// A header completion wins over the end code and over plain data.
		if (prev_q == ufr_pkg::HDR_FIRST && rx.rx_byte == ufr_pkg::HDR_SECOND) begin
			push_item.cls = ufr_pkg::CLS_HEADER;
		end else if (rx.rx_byte == ufr_pkg::END_BYTE) begin
			push_item.cls = ufr_pkg::CLS_END;
		end else begin
			push_item.cls = ufr_pkg::CLS_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			prev_q <= '0;
		end else if (accept) begin
			ptr_q  <= ptr_next;
			prev_q <= rx.rx_byte;
		end
	end

endmodule

>>> src/ufr_queue.sv
// Short queue of classified bytes between the front and the back part.
// Depends on ufr_pkg.

module ufr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  ufr_pkg::item_t         push_item,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output ufr_pkg::item_t         pop_item,
	output ufr_pkg::queue_status_t status
);

	localparam int DEPTH = ufr_pkg::QUEUE_DEPTH;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ufr_pkg::item_t   mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);
	assign push_ready   = !status.full;
	assign pop_valid    = !status.empty;
	assign pop_item     = mem_q[rd_q];
	assign push         = push_valid && push_ready;
	assign pop          = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IDX_LAST) ? '0 : wr_q + IDX_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == IDX_LAST) ? '0 : rd_q + IDX_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> src/ufr_back.sv
// Back part: keeps the frame state (sum, length, start, flags) and produces
// one registered result per classified byte. Depends on ufr_pkg and ufr_out_if.

module ufr_back #(
	parameter int BUFFER_DEPTH = ufr_pkg::BUFFER_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  ufr_pkg::item_t         pop_item,
	input  ufr_pkg::queue_status_t status,
	ufr_out_if.source              result
);

	localparam int LEN_LIMIT_I = (BUFFER_DEPTH > ufr_pkg::COUNT_MAX) ?
		ufr_pkg::COUNT_MAX : BUFFER_DEPTH;
	localparam logic [8:0] LEN_LIMIT = 9'(LEN_LIMIT_I);

	logic       sum_zero;
	logic [7:0] run_sum_q;
	logic [8:0] count_q;
	logic [7:0] start_q;
	logic       open_q;
	logic       ended_q;

	logic [7:0] sum_d;
	logic [8:0] count_d;
	logic [7:0] start_d;
	logic       open_d;
	logic       ended_d;
	logic       ok_d;
	logic       bad_d;
	logic       pop;

	logic       out_valid_q;
	logic [7:0] out_index_q;
	logic       out_ok_q;
	logic       out_bad_q;
	logic [7:0] out_start_q;
	logic [8:0] out_length_q;

	// The output register frees up whenever its result is being taken.
	assign pop_ready = !out_valid_q || result.ready;
	assign pop       = pop_valid && pop_ready && !status.empty;
	assign sum_zero  = (run_sum_q == 8'd0);

	always_comb begin
		sum_d   = run_sum_q;
		count_d = count_q;
		start_d = start_q;
		open_d  = open_q;
		ended_d = ended_q;
		ok_d    = 1'b0;
		bad_d   = 1'b0;
		unique case (pop_item.cls)
			ufr_pkg::CLS_HEADER: begin
				open_d  = 1'b1;
				ended_d = 1'b0;
				sum_d   = 8'd0;
				count_d = 9'd0;
				start_d = pop_item.next_slot;
			end
			ufr_pkg::CLS_END: begin
				if (open_q && !ended_q) begin
					ended_d = 1'b1;
					if (sum_zero) begin
						ok_d = 1'b1;
					end else begin
						bad_d   = 1'b1;
						sum_d   = 8'd0;
						count_d = 9'd0;
					end
				end
			end
			ufr_pkg::CLS_DATA: begin
				if (open_q && !ended_q) begin
					sum_d = run_sum_q + pop_item.rx_byte;
					if (count_q < LEN_LIMIT) begin
						count_d = count_q + 9'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_sum_q   <= '0;
			count_q     <= '0;
			start_q     <= '0;
			open_q      <= 1'b0;
			ended_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				run_sum_q   <= sum_d;
				count_q     <= count_d;
				start_q     <= start_d;
				open_q      <= open_d;
				ended_q     <= ended_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_index_q  <= pop_item.slot;
			out_ok_q     <= ok_d;
			out_bad_q    <= bad_d;
			out_start_q  <= start_d;
			out_length_q <= count_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.write_index  = out_index_q;
	assign result.frame_ok     = out_ok_q;
	assign result.frame_bad    = out_bad_q;
	assign result.frame_start  = out_start_q;
	assign result.frame_length = out_length_q;

endmodule

>>> src/ufr_checker.sv
// Port-level checks for the UART frame receiver, attached by bind.
// Depends on ufr_pkg and the top level uart_frame_receiver.

module ufr_checker #(
	parameter int BUFFER_DEPTH = ufr_pkg::BUFFER_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] write_index,
	input logic       frame_ok,
	input logic       frame_bad,
	input logic [7:0] frame_start,
	input logic [8:0] frame_length
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

	logic [PTR_W-1:0] exp_ptr_q;
	logic [PTR_W+7:0] exp_ext;
	logic [2:0]       pending_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign exp_ext  = {8'd0, exp_ptr_q};

	// Expected slot of the next result and the number of bytes in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ptr_q <= '0;
			pending_q <= '0;
		end else begin
			if (out_xfer) begin
				exp_ptr_q <= (exp_ptr_q == PTR_LAST) ? '0 : exp_ptr_q + PTR_W'(1);
			end
			if (in_xfer && !out_xfer) begin
				pending_q <= pending_q + 3'd1;
			end else if (out_xfer && !in_xfer) begin
				pending_q <= pending_q - 3'd1;
			end
		end
	end

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> write_index == exp_ext[7:0])
		else $error("result slot out of sequence");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result shown without a byte in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_ok && frame_bad))
		else $error("frame reported both good and bad");

	a_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_bad |-> frame_length == 9'd0)
		else $error("bad frame left a nonzero length");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_index)
			&& $stable(frame_ok) && $stable(frame_bad) && $stable(frame_start)
			&& $stable(frame_length))
		else $error("stalled result changed");

endmodule

bind uart_frame_receiver ufr_checker #(
	.BUFFER_DEPTH(BUFFER_DEPTH)
) u_ufr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (rx.valid),
	.in_ready    (rx.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.write_index (result.write_index),
	.frame_ok    (result.frame_ok),
	.frame_bad   (result.frame_bad),
	.frame_start (result.frame_start),
	.frame_length(result.frame_length)
);
